// ----- src/irpwd_pkg.sv -----
// Shared types and constants for the infrared pulse-width decoder.
// Used by the front classifier, the class queue, the back end and the top level.
package irpwd_pkg;

    localparam int WIDTH_W   = 8;
    localparam int FRAME_W   = 32;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration channel.
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEADER_MIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REPEAT_MIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN    = 3'd4;

    // Threshold values after reset.
    localparam logic [WIDTH_W-1:0] RST_TIMEOUT_MIN = 8'd250;
    localparam logic [WIDTH_W-1:0] RST_LEADER_MIN  = 8'd200;
    localparam logic [WIDTH_W-1:0] RST_REPEAT_MIN  = 8'd100;
    localparam logic [WIDTH_W-1:0] RST_ONE_MIN     = 8'd50;
    localparam logic [WIDTH_W-1:0] RST_ZERO_MIN    = 8'd10;

    // Depth of the queue between classifier and back end.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Pulse classes.
    typedef logic [2:0] pulse_class_t;
    localparam pulse_class_t CLS_NONE    = 3'd0;
    localparam pulse_class_t CLS_TIMEOUT = 3'd1;
    localparam pulse_class_t CLS_REPEAT  = 3'd2;
    localparam pulse_class_t CLS_LEADER  = 3'd3;
    localparam pulse_class_t CLS_ZERO    = 3'd4;
    localparam pulse_class_t CLS_ONE     = 3'd5;

    typedef struct packed {
        logic [WIDTH_W-1:0] timeout_min;
        logic [WIDTH_W-1:0] leader_min;
        logic [WIDTH_W-1:0] repeat_min;
        logic [WIDTH_W-1:0] one_min;
        logic [WIDTH_W-1:0] zero_min;
    } thresholds_t;

    // Handshake between queue and back end.
    typedef struct packed {
        logic         valid;
        pulse_class_t kind;
    } queue_head_t;

    typedef struct packed {
        logic              full;
        logic [QCNT_W-1:0] count;
    } queue_status_t;

endpackage

// ----- src/irpwd_front.sv -----
// Front end: threshold registers and the pulse-width classifier.
// Depends on irpwd_pkg.
module irpwd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    input  logic [irpwd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irpwd_pkg::WIDTH_W-1:0]       cfg_data,
    input  logic [irpwd_pkg::WIDTH_W-1:0]       pulse_width,
    output irpwd_pkg::pulse_class_t             pulse_kind
);

    irpwd_pkg::thresholds_t thr_reg;
    irpwd_pkg::thresholds_t thr_next;

    logic is_timeout;
    logic is_repeat;
    logic is_leader;
    logic is_zero;
    logic is_one;

    always_comb begin
        thr_next = thr_reg;
        if (cfg_valid) begin
            case (cfg_index)
                irpwd_pkg::REG_TIMEOUT_MIN: thr_next.timeout_min = cfg_data;
                irpwd_pkg::REG_LEADER_MIN:  thr_next.leader_min  = cfg_data;
                irpwd_pkg::REG_REPEAT_MIN:  thr_next.repeat_min  = cfg_data;
                irpwd_pkg::REG_ONE_MIN:     thr_next.one_min     = cfg_data;
                irpwd_pkg::REG_ZERO_MIN:    thr_next.zero_min    = cfg_data;
                default:                    thr_next = thr_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg.timeout_min <= irpwd_pkg::RST_TIMEOUT_MIN;
            thr_reg.leader_min  <= irpwd_pkg::RST_LEADER_MIN;
            thr_reg.repeat_min  <= irpwd_pkg::RST_REPEAT_MIN;
            thr_reg.one_min     <= irpwd_pkg::RST_ONE_MIN;
            thr_reg.zero_min    <= irpwd_pkg::RST_ZERO_MIN;
        end else begin
            thr_reg <= thr_next;
        end
    end

    // The rules are tested strictly in priority order, so overlapping or
    // unordered thresholds resolve to the first match.  A repeat wins over
    // the bit classes because it is tested before them.
    always_comb begin
        is_timeout = (pulse_width >= thr_reg.timeout_min);
        is_repeat  = !is_timeout && (pulse_width >= thr_reg.repeat_min)
                     && (pulse_width < thr_reg.leader_min);
        is_leader  = !is_timeout && !is_repeat && (pulse_width >= thr_reg.leader_min);
        is_zero    = !is_timeout && !is_repeat && !is_leader
                     && (pulse_width >= thr_reg.zero_min) && (pulse_width < thr_reg.one_min);
        is_one     = !is_timeout && !is_repeat && !is_leader && !is_zero
                     && (pulse_width >= thr_reg.one_min)
                     && (pulse_width < thr_reg.repeat_min);

        if (is_timeout) begin
            pulse_kind = irpwd_pkg::CLS_TIMEOUT;
        end else if (is_repeat) begin
            pulse_kind = irpwd_pkg::CLS_REPEAT;
        end else if (is_leader) begin
            pulse_kind = irpwd_pkg::CLS_LEADER;
        end else if (is_zero) begin
            pulse_kind = irpwd_pkg::CLS_ZERO;
        end else if (is_one) begin
            pulse_kind = irpwd_pkg::CLS_ONE;
        end else begin
            pulse_kind = irpwd_pkg::CLS_NONE;
        end
    end

endmodule

// ----- src/irpwd_queue.sv -----
// Short queue of classified pulses between the front and back ends.
// Depends on irpwd_pkg.
module irpwd_queue (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        push,
    input  irpwd_pkg::pulse_class_t     push_kind,
    input  logic                        pop,
    output irpwd_pkg::queue_head_t      head,
    output irpwd_pkg::queue_status_t    status
);

    irpwd_pkg::pulse_class_t entry_reg [irpwd_pkg::QUEUE_DEPTH];

    logic [irpwd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [irpwd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [irpwd_pkg::QCNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    localparam logic [irpwd_pkg::QCNT_W-1:0] FULL_COUNT =
        irpwd_pkg::QCNT_W'(irpwd_pkg::QUEUE_DEPTH);
    localparam logic [irpwd_pkg::QPTR_W-1:0] LAST_PTR =
        irpwd_pkg::QPTR_W'(irpwd_pkg::QUEUE_DEPTH - 1);

    assign status.full  = (count_reg == FULL_COUNT);
    assign status.count = count_reg;
    assign head.valid   = (count_reg != '0);
    assign head.kind    = entry_reg[rd_ptr_reg];

    assign do_push = push && !status.full;
    assign do_pop  = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_kind;
        end
    end

endmodule

// ----- src/irpwd_back.sv -----
// Back end: burst state, frame shift register, counters and the result register.
// Depends on irpwd_pkg.
module irpwd_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  irpwd_pkg::queue_head_t              head,
    output logic                                pop,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [irpwd_pkg::FRAME_W-1:0]       frame_word,
    output logic [irpwd_pkg::COUNT_W-1:0]       repeat_count,
    output logic [irpwd_pkg::COUNT_W-1:0]       press_count,
    output logic                                repeat_seen,
    output logic                                burst_end
);

    logic                             leader_reg, leader_next;
    logic                             bit_reg, bit_next;
    logic [irpwd_pkg::FRAME_W-1:0]    shift_reg, shift_next;
    logic [irpwd_pkg::COUNT_W-1:0]    repeats_reg, repeats_next;
    logic [irpwd_pkg::COUNT_W-1:0]    presses_reg, presses_next;
    logic                             valid_reg, valid_next;
    logic                             rep_reg, rep_next;
    logic                             end_reg, end_next;

    logic lead_upd;
    logic bit_upd;

    // The state registers are the result payload, so an item is only taken
    // from the queue once the previous result has gone or is going.
    assign pop = head.valid && (!valid_reg || out_ready);

    always_comb begin
        leader_next  = leader_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        repeats_next = repeats_reg;
        presses_next = presses_reg;
        rep_next     = rep_reg;
        end_next     = end_reg;
        valid_next   = valid_reg && !out_ready;

        lead_upd = leader_reg || (head.kind == irpwd_pkg::CLS_LEADER);
        case (head.kind)
            irpwd_pkg::CLS_ZERO: bit_upd = 1'b0;
            irpwd_pkg::CLS_ONE:  bit_upd = 1'b1;
            default:             bit_upd = bit_reg;
        endcase

        if (pop) begin
            valid_next = 1'b1;
            rep_next   = (head.kind == irpwd_pkg::CLS_REPEAT);
            end_next   = (head.kind == irpwd_pkg::CLS_REPEAT)
                         || (head.kind == irpwd_pkg::CLS_TIMEOUT);
            if (head.kind == irpwd_pkg::CLS_REPEAT) begin
                repeats_next = repeats_reg + 1'b1;
                presses_next = presses_reg + 1'b1;
            end else if (head.kind != irpwd_pkg::CLS_TIMEOUT && lead_upd) begin
                shift_next   = {shift_reg[irpwd_pkg::FRAME_W-2:0], bit_upd};
                repeats_next = '0;
                presses_next = irpwd_pkg::COUNT_W'(1);
            end
            if (end_next) begin
                leader_next = 1'b0;
                bit_next    = 1'b0;
            end else begin
                leader_next = lead_upd;
                bit_next    = bit_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            leader_reg  <= 1'b0;
            bit_reg     <= 1'b0;
            shift_reg   <= '0;
            repeats_reg <= '0;
            presses_reg <= '0;
            valid_reg   <= 1'b0;
        end else begin
            leader_reg  <= leader_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            repeats_reg <= repeats_next;
            presses_reg <= presses_next;
            valid_reg   <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rep_reg <= rep_next;
        end_reg <= end_next;
    end

    assign out_valid    = valid_reg;
    assign frame_word   = shift_reg;
    assign repeat_count = repeats_reg;
    assign press_count  = presses_reg;
    assign repeat_seen  = rep_reg;
    assign burst_end    = end_reg;

endmodule

// ----- src/ir_pulse_width_decoder_core.sv -----
// Infrared pulse-width decoder: each transfer on the s_ channel carries one measured
// high-pulse width and yields exactly one result transfer on the m_ channel. The block
// takes one pulse per clock cycle while the queue is not full; a pulse is classified
// in the cycle it is accepted and pushed into a two-entry queue. The queue registers
// its class, and the back end pops it into the result registers that drive m_tvalid.
// The only limit on rate is the downstream ready: the back end updates its burst state
// at most once per cycle. Thresholds are to be written over the cfg_ channel only while
// the block is idle; the user must keep to this, the block itself does not enforce it.
// Depends on irpwd_pkg, irpwd_front, irpwd_queue and irpwd_back.
module ir_pulse_width_decoder_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration writes.
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [irpwd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [irpwd_pkg::WIDTH_W-1:0]       cfg_data,
    // Pulse input.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [7:0] pulse_width
    // Results.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [47:0]                         m_tdata,   // [31:0] frame_word,
                                                           // [39:32] repeat_count,
                                                           // [47:40] press_count
    output logic                                m_tuser,   // [0] repeat_seen
    output logic                                m_tlast    // burst_end
);

    irpwd_pkg::pulse_class_t   pulse_kind;
    irpwd_pkg::queue_head_t    q_head;
    irpwd_pkg::queue_status_t  q_status;
    logic                      q_pop;
    logic                      in_xfer;

    logic [irpwd_pkg::FRAME_W-1:0] frame_word;
    logic [irpwd_pkg::COUNT_W-1:0] repeat_count;
    logic [irpwd_pkg::COUNT_W-1:0] press_count;

    assign cfg_ready = 1'b1;
    assign s_tready  = !q_status.full;
    assign in_xfer   = s_tvalid && s_tready;

    irpwd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pulse_width (s_tdata),
        .pulse_kind  (pulse_kind)
    );

    irpwd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (in_xfer),
        .push_kind (pulse_kind),
        .pop       (q_pop),
        .head      (q_head),
        .status    (q_status)
    );

    irpwd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .head         (q_head),
        .pop          (q_pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .frame_word   (frame_word),
        .repeat_count (repeat_count),
        .press_count  (press_count),
        .repeat_seen  (m_tuser),
        .burst_end    (m_tlast)
    );

    assign m_tdata = {press_count, repeat_count, frame_word};

    // A repeat code always ends the burst.
    a_repeat_ends_burst: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("repeat result without burst end");

    // The input side only stalls when the queue is full.
    a_stall_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> q_status.count == irpwd_pkg::QCNT_W'(irpwd_pkg::QUEUE_DEPTH))
        else $error("input stalled with queue space free");

    // A queued pulse is handed on whenever the output register is free.
    a_no_idle_back: assert property (@(posedge aclk) disable iff (!aresetn)
        q_head.valid && !m_tvalid |=> m_tvalid)
        else $error("back end idle with a pulse queued");

endmodule
